>>> src/cst_pkg.sv
// shared constants and types of the congestion signal tracker
package cst_pkg;

    localparam int DEF_TICK_BITS = 32;
    localparam int DEF_FRAC_BITS = 8;
    localparam int INT_BITS      = 14;
    localparam int SAT_INT       = 16380;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SEND_AVG = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RECV_AVG = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATIO    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RTT,
        S_SGAP,
        S_SMUL,
        S_SSUM,
        S_RGAP,
        S_RMUL,
        S_RSUM,
        S_MIN,
        S_CHK,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

endpackage

>>> src/cst_alu.sv
// shared add/subtract unit with carry out
module cst_alu #(
    parameter int W = 33
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_res,
    output logic         o_carry
);

    logic [W-1:0] w_b;

    assign w_b = i_sub ? ~i_b : i_b;
    assign {o_carry, o_res} = {1'b0, i_a} + {1'b0, w_b} + (W + 1)'(i_sub);

endmodule

>>> src/congestion_signal_tracker.sv
// Takes one acknowledged packet's send and receive ticks per item and returns
// the send gap average, the receive gap average and the round trip ratio, all
// unsigned fixed point with FRAC_BITS fraction bits, saturated at 16380.0.
// Everything runs through one shared add/subtract unit under a sequencer, and
// the block takes no new item until the current one has finished. An item that
// only records ticks (a stored last tick is zero) goes from the round trip step
// straight to the result register. An item whose ratio is 2^14 or more, or whose
// minimum is zero, skips the divide. Any other item runs nine add/subtract steps
// for round trip time, gaps, averages, the minimum and the range check, then one
// restoring divide step per ratio bit, a clamp and the load. The next item
// can be accepted in the cycle after the result is loaded, even if that result
// still waits on the output; a result is held back in the last step while the
// one before it is still stalled. Config writes load the averages and the
// ratio directly, clamped to 16380.0, and are meant for while the block is idle.
module congestion_signal_tracker
    import cst_pkg::*;
#(
    parameter int TICK_BITS = DEF_TICK_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [TICK_BITS-1:0]        i_sent_tick,
    input  logic [TICK_BITS-1:0]        i_received_tick,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [INT_BITS+FRAC_BITS-1:0] o_send_gap_avg,
    output logic [INT_BITS+FRAC_BITS-1:0] o_recv_gap_avg,
    output logic [INT_BITS+FRAC_BITS-1:0] o_delay_ratio,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [INT_BITS+FRAC_BITS-1:0] i_cfg_data
);

    localparam int Q_BITS = INT_BITS + FRAC_BITS;
    localparam int AW     = (TICK_BITS + 1 > Q_BITS + 4) ? TICK_BITS + 1 : Q_BITS + 4;
    localparam int CNT_W  = $clog2(Q_BITS);
    localparam logic [Q_BITS-1:0] SAT_Q     = Q_BITS'(SAT_INT) << FRAC_BITS;
    localparam logic [AW-1:0]     HUGE_GAP  = AW'(8 * SAT_INT);
    localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(Q_BITS - 1);

    t_state r_state, n_state;

    logic [TICK_BITS-1:0] r_sent, r_recv, r_rtt, r_gap;
    logic [TICK_BITS-1:0] r_prev_sent, r_prev_recv, r_least, r_rem;
    logic [Q_BITS-1:0]    r_send_avg, r_recv_avg, r_ratio;
    logic [Q_BITS-1:0]    r_dsh, r_quo;
    logic [AW-1:0]        r_acc;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    logic [Q_BITS-1:0]    r_out_send, r_out_recv, r_out_ratio;

    logic [AW-1:0]        w_a, w_b, w_res;
    logic                 w_sub, w_carry;
    logic                 w_record, w_huge, w_out_free, w_load;
    logic [Q_BITS-1:0]    w_avg, w_ewma, w_cfg_val, w_quo_next;
    logic [TICK_BITS:0]   w_div_a;

    cst_alu #(
        .W(AW)
    ) u_alu (
        .i_a    (w_a),
        .i_b    (w_b),
        .i_sub  (w_sub),
        .o_res  (w_res),
        .o_carry(w_carry)
    );

    assign w_record   = (r_prev_sent == '0) || (r_prev_recv == '0);
    assign w_huge     = AW'(r_gap) > HUGE_GAP;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == S_DONE) && w_out_free;
    assign w_avg      = (r_state == S_SMUL || r_state == S_SSUM) ? r_send_avg : r_recv_avg;
    assign w_ewma     = (w_huge || (w_res[AW-1:3] > (AW - 3)'(SAT_Q))) ? SAT_Q
                                                                    : w_res[Q_BITS+2:3];
    assign w_cfg_val  = (i_cfg_data > SAT_Q) ? SAT_Q : i_cfg_data;
    assign w_div_a    = {r_rem, r_dsh[Q_BITS-1]};
    assign w_quo_next = {r_quo[Q_BITS-2:0], w_carry};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_RTT;
            S_RTT:  n_state = w_record ? S_DONE : S_SGAP;
            S_SGAP: n_state = S_SMUL;
            S_SMUL: n_state = S_SSUM;
            S_SSUM: n_state = S_RGAP;
            S_RGAP: n_state = S_RMUL;
            S_RMUL: n_state = S_RSUM;
            S_RSUM: n_state = S_MIN;
            S_MIN:  n_state = S_CHK;
            S_CHK:  n_state = w_carry ? S_DONE : S_DIV;
            S_DIV:  if (r_cnt == LAST_STEP) n_state = S_FIN;
            S_FIN:  n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // operand select for the shared unit
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b1;
        unique case (r_state) inside
            S_RTT: begin
                w_a = AW'(r_recv);
                w_b = AW'(r_sent);
            end
            S_SGAP: begin
                w_a = AW'(r_sent);
                w_b = AW'(r_prev_sent);
            end
            S_RGAP: begin
                w_a = AW'(r_recv);
                w_b = AW'(r_prev_recv);
            end
            S_SMUL, S_RMUL: begin
                w_a = AW'(w_avg) << 3;
                w_b = AW'(w_avg);
            end
            S_SSUM, S_RSUM: begin
                w_a   = r_acc;
                w_b   = AW'(r_gap) << FRAC_BITS;
                w_sub = 1'b0;
            end
            S_MIN: begin
                w_a = AW'(r_rtt);
                w_b = AW'(r_least);
            end
            S_CHK: begin
                w_a = AW'(r_rtt >> INT_BITS);
                w_b = AW'(r_least);
            end
            S_DIV: begin
                w_a = AW'(w_div_a);
                w_b = AW'(r_least);
            end
            default: begin
                w_a   = '0;
                w_b   = '0;
                w_sub = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_send_avg  <= '0;
            r_recv_avg  <= '0;
            r_ratio     <= '0;
            r_prev_sent <= '0;
            r_prev_recv <= '0;
            r_least     <= '0;
        end else begin
            r_state <= n_state;

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SEND_AVG: r_send_avg <= w_cfg_val;
                    CFG_RECV_AVG: r_recv_avg <= w_cfg_val;
                    CFG_RATIO:    r_ratio    <= w_cfg_val;
                    default: ;
                endcase
            end

            unique case (r_state) inside
                S_IDLE: begin
                    r_sent <= i_sent_tick;
                    r_recv <= i_received_tick;
                end
                S_RTT: begin
                    r_rtt <= w_res[TICK_BITS-1:0];
                    if (w_record) begin
                        r_least     <= w_res[TICK_BITS-1:0];
                        r_prev_sent <= r_sent;
                        r_prev_recv <= r_recv;
                    end
                end
                S_SGAP, S_RGAP: r_gap <= w_res[TICK_BITS-1:0];
                S_SMUL, S_RMUL: r_acc <= w_res;
                S_SSUM: begin
                    r_send_avg  <= w_ewma;
                    r_prev_sent <= r_sent;
                end
                S_RSUM: begin
                    r_recv_avg  <= w_ewma;
                    r_prev_recv <= r_recv;
                end
                S_MIN: if (!w_carry) r_least <= r_rtt;
                S_CHK: begin
                    // quotient of 2^14 or more is past saturation; zero minimum lands here too
                    if (w_carry) r_ratio <= SAT_Q;
                    r_rem <= r_rtt >> INT_BITS;
                    r_dsh <= {r_rtt[INT_BITS-1:0], FRAC_BITS'(0)};
                    r_quo <= '0;
                    r_cnt <= '0;
                end
                S_DIV: begin
                    r_rem <= w_carry ? w_res[TICK_BITS-1:0] : w_div_a[TICK_BITS-1:0];
                    r_dsh <= r_dsh << 1;
                    r_quo <= w_quo_next;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                S_FIN: r_ratio <= (r_quo > SAT_Q) ? SAT_Q : r_quo;
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_send  <= r_send_avg;
                        r_out_recv  <= r_recv_avg;
                        r_out_ratio <= r_ratio;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_send_gap_avg = r_out_send;
    assign o_recv_gap_avg = r_out_recv;
    assign o_delay_ratio  = r_out_ratio;

endmodule

>>> src/cst_checker.sv
// port level checks of the congestion signal tracker, bound to the top level
module cst_checker
    import cst_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [INT_BITS+FRAC_BITS-1:0] o_send_gap_avg,
    input logic [INT_BITS+FRAC_BITS-1:0] o_recv_gap_avg,
    input logic [INT_BITS+FRAC_BITS-1:0] o_delay_ratio
);

    localparam int Q_BITS = INT_BITS + FRAC_BITS;
    localparam logic [Q_BITS-1:0] SAT_Q = Q_BITS'(SAT_INT) << FRAC_BITS;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset leaves an item pending");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block ready right after taking an item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_send_gap_avg)
            && $stable(o_recv_gap_avg) && $stable(o_delay_ratio))
        else $error("stalled result item changed");

    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_send_gap_avg <= SAT_Q && o_recv_gap_avg <= SAT_Q
            && o_delay_ratio <= SAT_Q)
        else $error("result above saturation");

endmodule

bind congestion_signal_tracker cst_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_cst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_send_gap_avg(o_send_gap_avg),
    .o_recv_gap_avg(o_recv_gap_avg),
    .o_delay_ratio (o_delay_ratio)
);
